// File: hdl/hggo_pkg.sv
// Package for the height grid gradient obstacle block.
// Holds command codes, state type, constants and shared structs; no dependencies.
package hggo_pkg;

  localparam int unsigned GridSideDefault   = 2800;
  localparam int unsigned WindowHalfDefault = 10;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_EVAL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CLASS_FLAT     = 2'd0,
    CLASS_STEP     = 2'd1,
    CLASS_OBSTACLE = 2'd2,
    CLASS_EMPTY    = 2'd3
  } cell_class_t;

  localparam logic REG_ROBOT_X = 1'b0;
  localparam logic REG_ROBOT_Y = 1'b1;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOAD_CHECK,
    ST_LOAD_READ,
    ST_LOAD_WRITE,
    ST_EVAL_CENTER,
    ST_EVAL_WAIT,
    ST_EVAL_SCAN,
    ST_EVAL_DRAIN,
    ST_EVAL_DONE,
    ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;
    logic sweep_clear;
    logic sweep_step;
    logic load_calc;
    logic load_read;
    logic load_write;
    logic eval_setup;
    logic center_read;
    logic scan_read;
    logic scan_step;
    logic eval_finish;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic sweep_last;
    logic load_ok;
    logic eval_ok;
    logic scan_last;
    cmd_t cmd;
  } dp_status_t;

endpackage

// File: hdl/hggo_if.sv
// Valid/ready channel interfaces for the height grid block.
// Depends on no package; widths are fixed by the item fields.
interface hggo_in_if (input logic clk);
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] point_x_mm;
  logic signed [15:0] point_y_mm;
  logic signed [15:0] point_z_mm;
  logic [11:0]        query_row;
  logic [11:0]        query_col;
  modport source (input clk, ready, output valid, cmd, point_x_mm, point_y_mm, point_z_mm,
                  query_row, query_col);
  modport sink (input clk, valid, cmd, point_x_mm, point_y_mm, point_z_mm, query_row,
                query_col, output ready);
endinterface

interface hggo_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [11:0] cell_row;
  logic [11:0] cell_col;
  logic [7:0]  height_range;
  logic [1:0]  cell_class;
  modport source (input clk, ready, output valid, cell_row, cell_col, height_range,
                  cell_class);
  modport sink (input clk, valid, cell_row, cell_col, height_range, cell_class,
                output ready);
endinterface

interface hggo_cfg_if (input logic clk);
  logic               valid;
  logic               ready;
  logic               index;
  logic [15:0]        data;
  modport source (input clk, ready, output valid, index, data);
  modport sink (input clk, valid, index, data, output ready);
endinterface

// File: hdl/hggo_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module hggo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: hdl/hggo_datapath.sv
// Datapath: item capture, load checks, grid memory, window scan and result.
// Depends on hggo_pkg and hggo_ram.
module hggo_datapath #(
  parameter int unsigned GridSide   = hggo_pkg::GridSideDefault,
  parameter int unsigned WindowHalf = hggo_pkg::WindowHalfDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  hggo_pkg::dp_cmd_t   cmd_i,
  output hggo_pkg::dp_status_t status,
  input  logic [1:0]          in_cmd,
  input  logic signed [15:0]  in_x,
  input  logic signed [15:0]  in_y,
  input  logic signed [15:0]  in_z,
  input  logic [11:0]         in_row,
  input  logic [11:0]         in_col,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output logic [11:0]         res_row,
  output logic [11:0]         res_col,
  output logic [7:0]          res_range,
  output logic [1:0]          res_class
);
  import hggo_pkg::*;

  localparam int unsigned Depth = GridSide * GridSide;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(GridSide + 1);

  logic signed [15:0] robot_x, robot_y;
  logic [1:0]         cmd_r;
  logic signed [15:0] px, py, pz;
  logic [11:0]        qrow, qcol;

  always_ff @(posedge clk) begin
    if (rst) begin
      robot_x <= '0;
      robot_y <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROBOT_X) robot_x <= cfg_data;
      else robot_y <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_r <= in_cmd;
      px    <= in_x;
      py    <= in_y;
      pz    <= in_z;
      qrow  <= in_row;
      qcol  <= in_col;
    end
  end

  // Load arithmetic.
  logic signed [17:0] zl;
  logic signed [17:0] dx, dy;
  logic        [35:0] dsq;
  logic               box_ok;
  logic [14:0]        xo, yo;
  logic [11:0]        zo;
  logic [11:0]        lrow, lcol;
  logic [7:0]         lcode;
  logic               lok;

  always_comb begin
    zl     = 18'(pz) + 18'sd520;
    box_ok = (px < 16'sd22400) && (px > -16'sd5400) && (py < 16'sd13800) &&
             (py > -16'sd13800) && (zl > -18'sd1200) && (zl < 18'sd1200);
    dx     = 18'(robot_x) - 18'(px);
    dy     = 18'(robot_y) - 18'(py);
    xo     = 15'(18'(px) + 18'sd5500);
    yo     = 15'(18'(py) + 18'sd14000);
    zo     = 12'(zl + 18'sd1300);
  end

  // Constant divisions by ten as reciprocal multiplies (exact for these ranges).
  function automatic logic [11:0] div10(input logic [14:0] v);
    logic [31:0] p;
    begin
      p = 32'(v) * 32'd52429;
      return 12'(p >> 19);
    end
  endfunction

  logic [35:0] dxx, dyy;
  always_ff @(posedge clk) begin
    if (cmd_i.load_calc) begin
      dxx   <= 36'($signed(dx) * $signed(dx));
      dyy   <= 36'($signed(dy) * $signed(dy));
      lrow  <= div10(xo);
      lcol  <= div10(yo);
      lcode <= 8'(div10(15'(zo)));
      lok   <= box_ok;
    end
  end
  assign dsq = dxx + dyy;

  logic load_ok_w;
  assign load_ok_w = lok && (dsq >= 36'd67000) && (32'(lrow) < GridSide) &&
                     (32'(lcol) < GridSide);

  // Window scan state.
  logic [CW-1:0] r0, r1, c0, c1, ri, ci;
  logic [7:0]    mx, mn;
  logic          eval_ok_r;
  logic [AW-1:0] sweep_addr;

  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [7:0]    ram_wdata, ram_rdata;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(GridSide) + AW'(c);
  endfunction

  logic [CW-1:0] qr_c, qc_c;
  assign qr_c = CW'(qrow);
  assign qc_c = CW'(qcol);

  logic [AW-1:0] addr_q;
  always_ff @(posedge clk) begin
    if (cmd_i.eval_setup) addr_q <= cell_addr(qr_c, qc_c);
    else if (cmd_i.load_calc) addr_q <= '0;
    else if (cmd_i.load_read) addr_q <= cell_addr(CW'(lrow), CW'(lcol));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = lcode;
    ram_addr  = addr_q;
    if (cmd_i.sweep_clear) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
      ram_addr  = sweep_addr;
    end else if (cmd_i.load_read) begin
      ram_addr = cell_addr(CW'(lrow), CW'(lcol));
    end else if (cmd_i.load_write) begin
      ram_we = (ram_rdata == 8'd0) || (lcode > ram_rdata);
    end else if (cmd_i.scan_read) begin
      ram_addr = cell_addr(ri, ci);
    end
  end

  hggo_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd_i.sweep_step) begin
      sweep_addr <= (32'(sweep_addr) == Depth - 1) ? '0 : sweep_addr + AW'(1);
    end
  end

  logic in_grid, masked;
  assign in_grid = (32'(qrow) < GridSide) && (32'(qcol) < GridSide);
  assign masked  = (qrow > 12'd1365) && (qrow < 12'd1435) && (qcol > 12'd1365) &&
                   (qcol < 12'd1435);

  logic rd_valid;
  always_ff @(posedge clk) begin
    if (cmd_i.eval_setup) begin
      r0 <= (32'(qrow) > WindowHalf) ? CW'(32'(qrow) - WindowHalf) : '0;
      r1 <= (32'(qrow) + WindowHalf < GridSide - 1) ? CW'(32'(qrow) + WindowHalf)
                                                     : CW'(GridSide - 1);
      c0 <= (32'(qcol) + 1 > WindowHalf) ? CW'(32'(qcol) + 1 - WindowHalf) : '0;
      c1 <= (32'(qcol) + WindowHalf - 1 < GridSide - 1) ? CW'(32'(qcol) + WindowHalf - 1)
                                                         : CW'(GridSide - 1);
      ri <= (32'(qrow) > WindowHalf) ? CW'(32'(qrow) - WindowHalf) : '0;
      ci <= (32'(qcol) + 1 > WindowHalf) ? CW'(32'(qcol) + 1 - WindowHalf) : '0;
      mx <= 8'd0;
      mn <= 8'd255;
    end else begin
      if (cmd_i.scan_step) begin
        if (ci == c1) begin
          ci <= c0;
          ri <= ri + CW'(1);
        end else begin
          ci <= ci + CW'(1);
        end
      end
      if (rd_valid && ram_rdata != 8'd0) begin
        if (ram_rdata < mn) mn <= ram_rdata;
        if (ram_rdata > mx) mx <= ram_rdata;
      end
    end
    if (cmd_i.center_read) eval_ok_r <= in_grid && !masked && (ram_rdata != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) rd_valid <= 1'b0;
    else rd_valid <= cmd_i.scan_read && (ri < r1);
  end

  logic [7:0] rng;
  assign rng = (mx >= mn) ? mx - mn : 8'd0;

  always_ff @(posedge clk) begin
    if (cmd_i.eval_finish) begin
      res_row <= qrow;
      res_col <= qcol;
      if (eval_ok_r) begin
        res_range <= rng;
        res_class <= (rng > 8'd14) ? CLASS_OBSTACLE : (rng > 8'd10) ? CLASS_STEP : CLASS_FLAT;
      end else begin
        res_range <= '0;
        res_class <= CLASS_EMPTY;
      end
    end
  end

  assign status.sweep_last = (32'(sweep_addr) == Depth - 1);
  assign status.load_ok    = load_ok_w;
  assign status.eval_ok    = in_grid;
  assign status.scan_last  = (ri >= r1) || ((ci == c1) && (ri + CW'(1) >= r1));
  assign status.cmd        = cmd_t'(cmd_r);
endmodule

// File: hdl/hggo_ctrl.sv
// Controller state machine for the height grid block.
// Depends on hggo_pkg.
module hggo_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hggo_pkg::dp_cmd_t    cmd_o,
  input  hggo_pkg::dp_status_t status
);
  import hggo_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_SWEEP;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_o      = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_SWEEP: begin
        cmd_o.sweep_clear = 1'b1;
        cmd_o.sweep_step  = 1'b1;
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd_o.capture = in_valid;
        if (in_valid) state_next = ST_LOAD_CHECK;
      end
      ST_LOAD_CHECK: begin
        unique case (status.cmd)
          CMD_LOAD: begin
            cmd_o.load_calc = 1'b1;
            state_next = ST_LOAD_READ;
          end
          CMD_EVAL: begin
            cmd_o.eval_setup = 1'b1;
            state_next = ST_EVAL_CENTER;
          end
          CMD_CLEAR: state_next = ST_SWEEP;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_LOAD_READ: begin
        cmd_o.load_read = 1'b1;
        state_next = status.load_ok ? ST_LOAD_WRITE : ST_IDLE;
      end
      ST_LOAD_WRITE: begin
        cmd_o.load_write = 1'b1;
        state_next = ST_IDLE;
      end
      ST_EVAL_CENTER: state_next = ST_EVAL_WAIT;
      ST_EVAL_WAIT: begin
        cmd_o.center_read = 1'b1;
        state_next = status.eval_ok ? ST_EVAL_SCAN : ST_EVAL_DONE;
      end
      ST_EVAL_SCAN: begin
        cmd_o.scan_read = 1'b1;
        cmd_o.scan_step = 1'b1;
        if (status.scan_last) state_next = ST_EVAL_DRAIN;
      end
      ST_EVAL_DRAIN: state_next = ST_EVAL_DONE;
      ST_EVAL_DONE: begin
        cmd_o.eval_finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// File: hdl/height_grid_gradient_obstacle.sv
// Top level of the height grid gradient obstacle block.
// Depends on hggo_pkg, hggo_if, hggo_ctrl and hggo_datapath.
//
//  channel  | direction | transaction
//  in       | sink      | one command: load point, evaluate cell or clear grid
//  out      | source    | one evaluation result
//  cfg      | sink      | robot position register write
//
// A load passes through check, read and write states; the write is skipped when the
// point is dropped. An evaluation of an interior cell reads a window of 2*WindowHalf
// rows by 2*WindowHalf-1 columns, one grid read per cycle from the single-port
// memory; a cell off the grid skips the window scan. After reset and after each
// clear, a pass writes zero to all GridSide*GridSide entries, one per cycle, with
// in.ready low. Items are taken one at a time; a held result blocks the next item.
module height_grid_gradient_obstacle #(
  parameter int unsigned GridSide   = hggo_pkg::GridSideDefault,
  parameter int unsigned WindowHalf = hggo_pkg::WindowHalfDefault
) (
  input logic       clk,
  input logic       rst,
  hggo_in_if.sink   in,
  hggo_out_if.source out,
  hggo_cfg_if.sink  cfg
);
  import hggo_pkg::*;

  dp_cmd_t    dcmd;
  dp_status_t dstat;

  assign cfg.ready = 1'b1;

  hggo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .cmd_o     (dcmd),
    .status    (dstat)
  );

  hggo_datapath #(.GridSide(GridSide), .WindowHalf(WindowHalf)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd_i     (dcmd),
    .status    (dstat),
    .in_cmd    (in.cmd),
    .in_x      (in.point_x_mm),
    .in_y      (in.point_y_mm),
    .in_z      (in.point_z_mm),
    .in_row    (in.query_row),
    .in_col    (in.query_col),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .res_row   (out.cell_row),
    .res_col   (out.cell_col),
    .res_range (out.height_range),
    .res_class (out.cell_class)
  );
endmodule
